/* rtl/bblf_pkg.sv */
// Shared types and constants of the box blur line filter.
`default_nettype none

package bblf_pkg;

  localparam int RAD_W      = 5;     // radius register
  localparam int LEN_W      = 13;    // line_length register
  localparam int RECIP_W    = 17;    // reciprocal register, Q1.16
  localparam int POS_W      = 12;    // position within a line
  localparam int MAX_LINE   = 4096;
  localparam int RING_DEPTH = 63;    // 2 * max radius + 1
  localparam int RING_AW    = 6;
  localparam int FRAC_BITS  = 16;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [RAD_W-1:0]   RADIUS_RST = '0;
  localparam logic [LEN_W-1:0]   LENGTH_RST = LEN_W'(4096);
  localparam logic [RECIP_W-1:0] RECIP_RST  = RECIP_W'(65536);

  typedef enum logic [1:0] {
    REG_RADIUS      = 2'd0,
    REG_LINE_LENGTH = 2'd1,
    REG_RECIPROCAL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [RAD_W-1:0]   radius;
    logic [LEN_W-1:0]   line_length;
    logic [RECIP_W-1:0] reciprocal;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/bblf_ram.sv */
// Generic single-write, registered-read RAM.
`default_nettype none

module bblf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 63
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/bblf_regs.sv */
// APB configuration registers of the box blur line filter.
`default_nettype none

module bblf_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bblf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bblf_pkg::DATA_W-1:0]   pwdata,
  output logic      [bblf_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output bblf_pkg::cfg_t                     cfg,
  output logic                               cfg_wr
);
  import bblf_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  // restart the line at the same edge that loads the register
  assign cfg_wr = wr_en && (idx == REG_RADIUS || idx == REG_LINE_LENGTH ||
                            idx == REG_RECIPROCAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius      <= RADIUS_RST;
      cfg.line_length <= LENGTH_RST;
      cfg.reciprocal  <= RECIP_RST;
    end else begin
      if (wr_en) begin
        unique case (idx)
          REG_RADIUS: begin
            cfg.radius <= pwdata[RAD_W-1:0];
          end
          REG_LINE_LENGTH: begin
            cfg.line_length <= pwdata[LEN_W-1:0];
          end
          REG_RECIPROCAL: begin
            cfg.reciprocal <= pwdata[RECIP_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_RADIUS:      prdata = DATA_W'(cfg.radius);
      REG_LINE_LENGTH: prdata = DATA_W'(cfg.line_length);
      REG_RECIPROCAL:  prdata = DATA_W'(cfg.reciprocal);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/box_blur_line_filter_core.sv */
// Box blur line filter: 1-D box average with edge replication over configured lines.
//
// Pixels enter on in_valid/in_stall, one line after another; results leave on
// out_valid/out_stall as blurred plus end_of_line. A transfer happens at a clock
// edge with valid high and stall low.
// A line of L pixels gives L results. The first R pixels give none; the last
// pixel gives R+1, the final one flagged with end_of_line. R is the radius
// clamped to (L-1)/2.
// Throughput: one pixel per cycle while the output is not stalled; at the end of
// each line the input stalls while the trailing results come out of the running
// sum. A result passes the sum stage (window_sum, s1_valid), then the output
// register (blurred, out_valid). The 63-entry pixel ring is a RAM with registered
// read, read at the next left pointer (tail_next) so the oldest window pixel is
// ready when it is needed. A stalled output holds; one result waits in the sum
// stage and the input stalls when both are full or while trailing results drain.
// Reset (rst, synchronous) empties the pipe, starts a new line and loads radius
// 0, line_length 4096, reciprocal 1.0. A write to any of the three registers also
// starts a new line; write registers only while the block is idle.
`default_nettype none

module box_blur_line_filter_core #(
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bblf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bblf_pkg::DATA_W-1:0] pwdata,
  output logic      [bblf_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  // pixel input
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [PIXEL_BITS-1:0]       pixel,
  // result output
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [PIXEL_BITS-1:0]       blurred,
  output logic                             end_of_line
);
  import bblf_pkg::*;

  localparam int SUM_W  = PIXEL_BITS + RING_AW;
  localparam int PROD_W = SUM_W + RECIP_W;

  cfg_t cfg;
  logic cfg_wr;

  bblf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // effective length and radius
  logic [LEN_W-1:0] eff_len;
  logic [POS_W-1:0] len_m1;
  logic [RAD_W-1:0] eff_r;

  always_comb begin
    if (cfg.line_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg.line_length > LEN_W'(MAX_LINE)) begin
      eff_len = LEN_W'(MAX_LINE);
    end else begin
      eff_len = cfg.line_length;
    end
    len_m1 = POS_W'(eff_len - LEN_W'(1));
    if (POS_W'(cfg.radius) > POS_W'(len_m1[POS_W-1:1])) begin
      eff_r = RAD_W'(len_m1[POS_W-1:1]);
    end else begin
      eff_r = cfg.radius;
    end
  end

  // state
  logic [POS_W-1:0]      position, position_next;
  logic [RING_AW-1:0]    wptr, wptr_next;
  logic [RING_AW-1:0]    tail, tail_next;
  logic [RAD_W-1:0]      drain_cnt, drain_cnt_next;
  logic [PIXEL_BITS-1:0] first_value, first_value_next;
  logic [PIXEL_BITS-1:0] last_pixel, last_pixel_next;
  logic [SUM_W-1:0]      window_sum, window_sum_next;
  logic                  s1_valid, s1_valid_next;
  logic                  s1_eol, s1_eol_next;

  logic [PIXEL_BITS-1:0] ring_rd;
  logic [PIXEL_BITS-1:0] left;
  logic                  accept, drain_step, out_free, s1_move, s1_free;
  logic                  line_end;
  logic [RING_AW-1:0]    tail_inc, tail_start;

  assign out_free   = !out_valid || !out_stall;
  assign s1_move    = s1_valid && out_free;
  assign s1_free    = !s1_valid || out_free;
  assign in_stall   = !(s1_free && (drain_cnt == '0));
  assign accept     = in_valid && !in_stall;
  assign drain_step = (drain_cnt != '0) && s1_free;
  assign line_end   = (position == len_m1);

  assign tail_inc   = (tail == RING_AW'(RING_DEPTH - 1)) ? '0 : tail + RING_AW'(1);
  // left pointer after the first pixel: -2R modulo the ring depth
  assign tail_start = (eff_r == '0) ? '0
                    : RING_AW'(RING_DEPTH) - {eff_r, 1'b0};

  always_comb begin
    if (position <= POS_W'({eff_r, 1'b0})) begin
      left = first_value;
    end else if (eff_r == '0) begin
      // the ring entry would be the one written by the previous pixel
      left = last_pixel;
    end else begin
      left = ring_rd;
    end
  end

  always_comb begin
    position_next    = position;
    wptr_next        = wptr;
    tail_next        = tail;
    drain_cnt_next   = drain_cnt;
    first_value_next = first_value;
    last_pixel_next  = last_pixel;
    window_sum_next  = window_sum;
    s1_valid_next    = s1_move ? 1'b0 : s1_valid;
    s1_eol_next      = s1_eol;

    if (accept) begin
      last_pixel_next = pixel;
      if (position == '0) begin
        first_value_next = pixel;
        window_sum_next  = SUM_W'(pixel) * SUM_W'({eff_r, 1'b1});
        tail_next        = tail_start;
      end else begin
        window_sum_next  = window_sum - SUM_W'(left) + SUM_W'(pixel);
        tail_next        = tail_inc;
      end
      s1_valid_next = (position >= POS_W'(eff_r));
      s1_eol_next   = line_end && (eff_r == '0);
      if (line_end) begin
        position_next  = '0;
        wptr_next      = '0;
        drain_cnt_next = eff_r;
      end else begin
        position_next  = position + POS_W'(1);
        wptr_next      = (wptr == RING_AW'(RING_DEPTH - 1)) ? '0 : wptr + RING_AW'(1);
      end
    end else if (drain_step) begin
      // trailing outputs: the right edge repeats the line's last pixel
      window_sum_next = window_sum - SUM_W'(ring_rd) + SUM_W'(last_pixel);
      tail_next       = tail_inc;
      drain_cnt_next  = drain_cnt - RAD_W'(1);
      s1_valid_next   = 1'b1;
      s1_eol_next     = (drain_cnt == RAD_W'(1));
    end

    if (cfg_wr) begin
      position_next = '0;
      wptr_next     = '0;
    end
  end

  bblf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wptr),
    .wr_data (pixel),
    .rd_addr (tail_next),
    .rd_data (ring_rd)
  );

  // scale by the reciprocal, round, saturate
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] rounded;
  logic [SUM_W:0]    scaled;
  logic [PIXEL_BITS-1:0] result;

  assign product = PROD_W'(window_sum) * PROD_W'(cfg.reciprocal);
  assign rounded = product + PROD_W'(1 << (FRAC_BITS - 1));
  assign scaled  = (SUM_W + 1)'(rounded[PROD_W-1:FRAC_BITS]);
  assign result  = (|scaled[SUM_W:PIXEL_BITS]) ? '1 : scaled[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      wptr        <= '0;
      tail        <= '0;
      drain_cnt   <= '0;
      first_value <= '0;
      last_pixel  <= '0;
      window_sum  <= '0;
      s1_valid    <= 1'b0;
      s1_eol      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      position    <= position_next;
      wptr        <= wptr_next;
      tail        <= tail_next;
      drain_cnt   <= drain_cnt_next;
      first_value <= first_value_next;
      last_pixel  <= last_pixel_next;
      window_sum  <= window_sum_next;
      s1_valid    <= s1_valid_next;
      s1_eol      <= s1_eol_next;
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      blurred     <= result;
      end_of_line <= s1_eol;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for box_blur_line_filter_core: directed table, then random lines.
module tb_top;
  import bblf_pkg::*;

  localparam int PIX_W        = 16;
  localparam int REG_UNUSED   = 3;       // first index past the register file
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEM_TARGET  = 230;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DIR_ROWS     = 39;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             eol;
  } avg_t;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct {
    row_kind_t         kind;
    int                reg_sel;
    logic [DATA_W-1:0] value;
    bit                known;
    logic [PIX_W-1:0]  want_blur;
    bit                want_eol;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PIX_W-1:0]  pixel = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PIX_W-1:0]  blurred;
  logic              end_of_line;

  // predictor state and register mirror
  logic [RAD_W-1:0]   cfg_radius = RADIUS_RST;
  logic [LEN_W-1:0]   cfg_length = LENGTH_RST;
  logic [RECIP_W-1:0] cfg_recip  = RECIP_RST;
  logic [PIX_W-1:0]   ring [RING_DEPTH] = '{default: '0};
  logic [21:0]        win_sum = '0;
  logic [PIX_W-1:0]   line_first = '0;
  logic [LEN_W-1:0]   line_pos = '0;

  avg_t        avg_queue[$];
  avg_t        fresh_avgs[$];
  bit          row_known = 1'b0;
  avg_t        row_want = '0;
  int          errors = 0;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  int unsigned cycle_count = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned mode_timer = 0;

  stim_row_t directed [DIR_ROWS] = '{
    // reset settings: radius 0, reciprocal 1.0, so output equals input
    '{ROW_PIXEL, 0, 32'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_PIXEL, 0, 32'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{ROW_PIXEL, 0, 32'h5A5A, 1'b1, 16'h5A5A, 1'b0},
    // one-pixel lines: every pixel ends its line
    '{ROW_WRITE, REG_LINE_LENGTH, 32'd1, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'hFFFF, 1'b1, 16'hFFFF, 1'b1},
    '{ROW_PIXEL, 0, 32'hA5A5, 1'b1, 16'hA5A5, 1'b1},
    '{ROW_WRITE, REG_RECIPROCAL, 32'd0, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h3039, 1'b1, 16'h0000, 1'b1},
    // largest reciprocal: saturation
    '{ROW_WRITE, REG_RECIPROCAL, 32'h1FFFF, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'hFFFF, 1'b1, 16'hFFFF, 1'b1},
    '{ROW_PIXEL, 0, 32'h0001, 1'b1, 16'h0002, 1'b1},
    // zero length acts as one
    '{ROW_WRITE, REG_LINE_LENGTH, 32'd0, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0007, 1'b0, 16'h0, 1'b0},
    '{ROW_WRITE, REG_RADIUS, 32'd31, 1'b0, 16'h0, 1'b0},
    '{ROW_WRITE, REG_RECIPROCAL, 32'h10000, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h012C, 1'b1, 16'h012C, 1'b1},
    // radius clamped to 2, reciprocal left at 1.0
    '{ROW_WRITE, REG_LINE_LENGTH, 32'd5, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0064, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'hFFFF, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0000, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h9C40, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0009, 1'b0, 16'h0, 1'b0},
    // over-range length acts as the maximum; line left unfinished
    '{ROW_WRITE, REG_RECIPROCAL, 32'd13107, 1'b0, 16'h0, 1'b0},
    '{ROW_WRITE, REG_LINE_LENGTH, 32'h1FFF, 1'b0, 16'h0, 1'b0},
    '{ROW_WRITE, REG_RADIUS, 32'd3, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h1111, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h2222, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h3333, 1'b0, 16'h0, 1'b0},
    // write past the register file must not restart the line
    '{ROW_WRITE, REG_UNUSED, 32'hFFFFFFFF, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h4444, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h5555, 1'b0, 16'h0, 1'b0},
    '{ROW_WRITE, REG_LINE_LENGTH, 32'd7, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0010, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'hFFFF, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h8000, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0001, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h7FFF, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'h0000, 1'b0, 16'h0, 1'b0},
    '{ROW_PIXEL, 0, 32'hABCD, 1'b0, 16'h0, 1'b0}
  };

  box_blur_line_filter_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .blurred    (blurred),
    .end_of_line(end_of_line)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [PIX_W-1:0] scaled_avg(input logic [21:0] sum);
    logic [39:0] prod;
    prod = (40'(sum) * 40'(cfg_recip) + 40'd32768) >> 16;
    return (prod > 40'hFFFF) ? 16'hFFFF : prod[PIX_W-1:0];
  endfunction

  // Running-sum box filter with edge replication; results land in fresh_avgs.
  task automatic blur_pixel(input logic [PIX_W-1:0] x);
    int unsigned len, r, p, k;
    logic [PIX_W-1:0] oldest;
    len = (cfg_length == '0) ? 1 : ((cfg_length > MAX_LINE) ? MAX_LINE : cfg_length);
    r = cfg_radius;
    if (r > (len - 1) / 2) r = (len - 1) / 2;
    p = line_pos;
    if (p >= len) p = 0;
    if (p == 0) begin
      line_first = x;
      win_sum = 22'((2 * r + 1) * x);
    end else begin
      oldest = (p <= 2 * r) ? line_first : ring[(p - 2 * r - 1) % RING_DEPTH];
      win_sum = win_sum - oldest + x;
    end
    ring[p % RING_DEPTH] = x;
    if (p >= r) fresh_avgs.push_back('{scaled_avg(win_sum), (p == len - 1) && (r == 0)});
    if (p == len - 1) begin
      // trailing outputs: right edge padded with the last pixel
      for (k = len - r; k < len; k++) begin
        win_sum = win_sum - ring[(k - r - 1) % RING_DEPTH] + x;
        fresh_avgs.push_back('{scaled_avg(win_sum), k == len - 1});
      end
      line_pos = '0;
    end else begin
      line_pos = LEN_W'(p + 1);
    end
  endtask

  task automatic check_avg(input bit expected, input avg_t want, input avg_t got);
    if (!expected || want !== got) begin
      errors++;
      if (errors <= 10) begin
        if (!expected)
          $display("unexpected result: blurred %h eol %b", got.blurred, got.eol);
        else
          $display("result mismatch: expected %h/%b, got %h/%b",
                   want.blurred, want.eol, got.blurred, got.eol);
      end
    end
  endtask

  // sample both transfers at the rising edge
  always @(posedge clk) begin
    avg_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{blurred, end_of_line};
        if (avg_queue.size() == 0) check_avg(1'b0, '0, got);
        else check_avg(1'b1, avg_queue.pop_front(), got);
      end
      if (in_valid && !in_stall) begin
        blur_pixel(pixel);
        if (row_known) avg_queue.push_back(row_want);
        else foreach (fresh_avgs[i]) avg_queue.push_back(fresh_avgs[i]);
        fresh_avgs.delete();
      end
    end
  end

  // receiver back-pressure, switching between patterns
  always @(negedge clk) begin
    if (mode_timer == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      mode_timer <= $urandom_range(16, 160);
    end else begin
      mode_timer <= mode_timer - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:  out_stall <= ((cycle_count % 16) < 9);
    endcase
  end

  // called at a falling edge; returns at a falling edge
  task automatic push_pixel(input logic [PIX_W-1:0] value, input bit known, input avg_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    row_known = known;
    row_want = want;
    in_valid <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // hold the sender until every expected result is out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (avg_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input int idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] mirror;
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= val;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    case (idx)
      int'(REG_RADIUS):      cfg_radius = val[RAD_W-1:0];
      int'(REG_LINE_LENGTH): cfg_length = val[LEN_W-1:0];
      int'(REG_RECIPROCAL):  cfg_recip = val[RECIP_W-1:0];
      default: ;
    endcase
    if (idx == REG_UNUSED) begin
      psel <= 1'b0;
      penable <= 1'b0;
    end else begin
      line_pos = '0;
      mirror = (idx == REG_RADIUS) ? DATA_W'(cfg_radius) :
               (idx == REG_LINE_LENGTH) ? DATA_W'(cfg_length) : DATA_W'(cfg_recip);
      // read back in the next transfer
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clk) penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== mirror) begin
        errors++;
        if (errors <= 10)
          $display("register %0d read back: expected %h, got %h", idx, mirror, prdata);
      end
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIX_W'($urandom_range(0, 65535));
  endfunction

  task automatic random_setup(output int unsigned len_eff);
    int unsigned rad, len, r_eff, sel;
    logic [RECIP_W-1:0] recip;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      rad = 31;
      len = $urandom_range(63, 66);
    end else if (sel == 1) begin
      rad = $urandom_range(0, 31);
      len = $urandom_range(0, 3);
    end else begin
      rad = (sel == 2) ? 0 : $urandom_range(0, 12);
      len = $urandom_range(4, 48);
    end
    len_eff = (len == 0) ? 1 : len;
    r_eff = rad;
    if (r_eff > (len_eff - 1) / 2) r_eff = (len_eff - 1) / 2;
    sel = $urandom_range(0, 9);
    if (sel == 0) recip = '0;
    else if (sel == 1) recip = '1;
    else if (sel == 2) recip = RECIP_W'($urandom_range(0, 131071));
    else recip = RECIP_W'((131072 / (2 * r_eff + 1) + 1) / 2);
    cfg_write(REG_RADIUS, rad);
    cfg_write(REG_LINE_LENGTH, len);
    cfg_write(REG_RECIPROCAL, DATA_W'(recip));
    if ($urandom_range(0, 7) == 0) cfg_write(REG_UNUSED, $urandom());
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("box_blur_line_filter_core regression: fail");
    $finish;
  end

  initial begin
    avg_t want;
    int unsigned len_eff, phase, lines, ln, j;
    int stop_at, pause_at;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed[i].kind == ROW_WRITE) begin
        cfg_write(directed[i].reg_sel, directed[i].value);
      end else begin
        want = '{directed[i].want_blur, directed[i].want_eol};
        push_pixel(directed[i].value[PIX_W-1:0], directed[i].known, want);
      end
    end

    // random lines, mostly complete, a few abandoned mid-way
    phase = 0;
    while (sent < ITEM_TARGET) begin
      random_setup(len_eff);
      steady = ($urandom_range(0, 3) == 0);
      lines = $urandom_range(1, 3);
      for (ln = 0; ln < lines; ln++) begin
        stop_at = len_eff;
        if (ln == lines - 1 && $urandom_range(0, 7) == 0) stop_at = $urandom_range(1, len_eff);
        pause_at = (phase == 1 || $urandom_range(0, 9) == 0) ? $urandom_range(0, stop_at - 1) : -1;
        for (j = 0; j < stop_at; j++) begin
          if (sent >= ITEM_TARGET) break;
          if (j == pause_at) drain_results();
          push_pixel(random_pixel(), 1'b0, '0);
        end
      end
      phase++;
    end

    drain_results();
    if (errors == 0) begin
      $display("box_blur_line_filter_core regression: pass");
    end else begin
      $display("box_blur_line_filter_core regression: fail");
    end
    $finish;
  end

endmodule
